// ----- src/abb_pkg.sv -----
package abb_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEST_ORIGIN_X   = 3'd0,
        CFG_DEST_ORIGIN_Y   = 3'd1,
        CFG_SOURCE_ORIGIN_X = 3'd2,
        CFG_SOURCE_ORIGIN_Y = 3'd3,
        CFG_RECT_WIDTH      = 3'd4,
        CFG_RECT_HEIGHT     = 3'd5
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int COORD_W     = 12;
    localparam int SIZE_W      = 11;
    localparam int INDEX_W     = 20;
    localparam int PIXEL_W     = 32;

    // Packed lane masks and blend constants
    localparam logic [31:0] RB_MASK      = 32'h00FF_00FF;
    localparam logic [31:0] G_MASK       = 32'h0000_FF00;
    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam int          BLEND_ONE    = 256;
    localparam int          ALPHA_LSB    = 24;
    localparam int          BLEND_SHIFT  = 8;

endpackage

// ----- src/alpha_blend_blit.sv -----
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     s_source_pixel, s_dest_pixel
// m_        out        m_valid / m_ready     m_blended_pixel, m_dest_index,
//                                            m_source_index, m_last_pixel
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per clock while m_ready is high and no geometry update runs; a result passes
// through the input register, then is blended into the output register.
// Reset or any write to a listed register starts a geometry update (size saturation,
// origin clamp, origin index multiply) during which s_ready is low.
// A stalled output holds one result and one more waits in the input register;
// s_ready drops when both are full and m_ready is low, and during a geometry update.
module alpha_blend_blit #(
    parameter int DST_WIDTH  = 1024,
    parameter int DST_HEIGHT = 1024,
    parameter int DST_PITCH  = 1024,
    parameter int SRC_WIDTH  = 1024,
    parameter int SRC_HEIGHT = 1024,
    parameter int SRC_PITCH  = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [abb_pkg::PIXEL_W-1:0]       s_source_pixel,
    input  logic [abb_pkg::PIXEL_W-1:0]       s_dest_pixel,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [abb_pkg::PIXEL_W-1:0]       m_blended_pixel,
    output logic [abb_pkg::INDEX_W-1:0]       m_dest_index,
    output logic [abb_pkg::INDEX_W-1:0]       m_source_index,
    output logic                              m_last_pixel,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [abb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [abb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int W_LIMIT = (DST_WIDTH < SRC_WIDTH) ? DST_WIDTH : SRC_WIDTH;
    localparam int H_LIMIT = (DST_HEIGHT < SRC_HEIGHT) ? DST_HEIGHT : SRC_HEIGHT;
    localparam int EXT_W   = 13;   // holds surface extents up to 4096
    localparam int CNT_W   = 12;   // position within the rectangle
    localparam int PROD_W  = 25;
    localparam logic [2:0] SETTLE_CYCLES = 3'd4;

    // Configuration registers
    logic [abb_pkg::COORD_W-1:0] dest_x_reg, dest_y_reg, source_x_reg, source_y_reg;
    logic [abb_pkg::SIZE_W-1:0]  rect_w_reg, rect_h_reg;
    logic                        cfg_hit;

    // Geometry pipeline
    logic [EXT_W-1:0]            eff_w_reg, eff_h_reg;
    logic [EXT_W-1:0]            eff_w_next, eff_h_next;
    logic [abb_pkg::COORD_W-1:0] dx_reg, dy_reg, sx_reg, sy_reg;
    logic [abb_pkg::INDEX_W-1:0] dest_origin_reg, source_origin_reg;
    logic [PROD_W-1:0]           dest_prod, source_prod;
    logic [2:0]                  settle_reg;

    // Walk state
    logic [CNT_W-1:0]            column_reg, row_reg;
    logic [abb_pkg::INDEX_W-1:0] dest_base_reg, source_base_reg;
    logic                        line_end, last_hit;

    // Pipeline stages
    logic                        s1_valid_reg;
    logic [abb_pkg::PIXEL_W-1:0] s1_source_reg, s1_dest_reg;
    logic [abb_pkg::INDEX_W-1:0] s1_dest_index_reg, s1_source_index_reg;
    logic                        s1_last_reg;
    logic                        s_xfer, advance;
    logic [abb_pkg::PIXEL_W-1:0] blend_pix;

    // Clamp one signed coordinate into [0, hi]
    function automatic logic [abb_pkg::COORD_W-1:0] clamp_coord(
        input logic [abb_pkg::COORD_W-1:0] coord,
        input logic [EXT_W-1:0]            hi
    );
        logic [EXT_W-1:0] mag;
        mag = {1'b0, coord};
        if (coord[abb_pkg::COORD_W-1]) begin
            return '0;
        end else if (mag > hi) begin
            return abb_pkg::COORD_W'(hi);
        end else begin
            return coord;
        end
    endfunction

    // Requested size, zero read as one, saturated to the limit
    function automatic logic [EXT_W-1:0] sat_size(
        input logic [abb_pkg::SIZE_W-1:0] req,
        input logic [EXT_W-1:0]           lim
    );
        logic [EXT_W-1:0] r;
        r = (req == '0) ? EXT_W'(1) : EXT_W'(req);
        return (r > lim) ? lim : r;
    endfunction

    assign cfg_ready = 1'b1;

    // Register decode; out-of-range indexes are dropped
    always_comb begin
        cfg_hit = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index) inside
                abb_pkg::CFG_DEST_ORIGIN_X,
                abb_pkg::CFG_DEST_ORIGIN_Y,
                abb_pkg::CFG_SOURCE_ORIGIN_X,
                abb_pkg::CFG_SOURCE_ORIGIN_Y,
                abb_pkg::CFG_RECT_WIDTH,
                abb_pkg::CFG_RECT_HEIGHT: cfg_hit = 1'b1;
                default:                  cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_x_reg   <= '0;
            dest_y_reg   <= '0;
            source_x_reg <= '0;
            source_y_reg <= '0;
            rect_w_reg   <= abb_pkg::SIZE_W'(1);
            rect_h_reg   <= abb_pkg::SIZE_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                abb_pkg::CFG_DEST_ORIGIN_X:   dest_x_reg   <= cfg_data;
                abb_pkg::CFG_DEST_ORIGIN_Y:   dest_y_reg   <= cfg_data;
                abb_pkg::CFG_SOURCE_ORIGIN_X: source_x_reg <= cfg_data;
                abb_pkg::CFG_SOURCE_ORIGIN_Y: source_y_reg <= cfg_data;
                abb_pkg::CFG_RECT_WIDTH:  rect_w_reg <= cfg_data[abb_pkg::SIZE_W-1:0];
                abb_pkg::CFG_RECT_HEIGHT: rect_h_reg <= cfg_data[abb_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Geometry: saturate sizes, clamp origins, then origin word indexes
    assign eff_w_next  = sat_size(rect_w_reg, EXT_W'(W_LIMIT));
    assign eff_h_next  = sat_size(rect_h_reg, EXT_W'(H_LIMIT));
    assign dest_prod   = PROD_W'(dy_reg) * PROD_W'(DST_PITCH);
    assign source_prod = PROD_W'(sy_reg) * PROD_W'(SRC_PITCH);

    always_ff @(posedge aclk) begin
        eff_w_reg         <= eff_w_next;
        eff_h_reg         <= eff_h_next;
        dx_reg            <= clamp_coord(dest_x_reg,   EXT_W'(DST_WIDTH)  - eff_w_reg);
        dy_reg            <= clamp_coord(dest_y_reg,   EXT_W'(DST_HEIGHT) - eff_h_reg);
        sx_reg            <= clamp_coord(source_x_reg, EXT_W'(SRC_WIDTH)  - eff_w_reg);
        sy_reg            <= clamp_coord(source_y_reg, EXT_W'(SRC_HEIGHT) - eff_h_reg);
        dest_origin_reg   <= abb_pkg::INDEX_W'(dest_prod + PROD_W'(dx_reg));
        source_origin_reg <= abb_pkg::INDEX_W'(source_prod + PROD_W'(sx_reg));
    end

    // Handshake
    assign advance = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = (settle_reg == '0) && (!s1_valid_reg || !m_valid || m_ready);
    assign s_xfer  = s_valid && s_ready;

    assign line_end = (EXT_W'(column_reg) + EXT_W'(1)) >= eff_w_reg;
    assign last_hit = line_end && ((EXT_W'(row_reg) + EXT_W'(1)) >= eff_h_reg);

    // Raster walk; restarts on reset, a write to a listed register and last pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
            column_reg <= '0;
            row_reg    <= '0;
        end else if (cfg_hit) begin
            settle_reg <= SETTLE_CYCLES;
            column_reg <= '0;
            row_reg    <= '0;
        end else if (settle_reg != '0) begin
            settle_reg      <= settle_reg - 3'd1;
            column_reg      <= '0;
            row_reg         <= '0;
            dest_base_reg   <= dest_origin_reg;
            source_base_reg <= source_origin_reg;
        end else if (s_xfer) begin
            if (last_hit) begin
                column_reg      <= '0;
                row_reg         <= '0;
                dest_base_reg   <= dest_origin_reg;
                source_base_reg <= source_origin_reg;
            end else if (line_end) begin
                column_reg      <= '0;
                row_reg         <= row_reg + CNT_W'(1);
                dest_base_reg   <= dest_base_reg + abb_pkg::INDEX_W'(DST_PITCH);
                source_base_reg <= source_base_reg + abb_pkg::INDEX_W'(SRC_PITCH);
            end else begin
                column_reg <= column_reg + CNT_W'(1);
            end
        end
    end

    // Input register: pixels plus the indexes of this position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
        if (s_xfer) begin
            s1_source_reg       <= s_source_pixel;
            s1_dest_reg         <= s_dest_pixel;
            s1_dest_index_reg   <= dest_base_reg + abb_pkg::INDEX_W'(column_reg);
            s1_source_index_reg <= source_base_reg + abb_pkg::INDEX_W'(column_reg);
            s1_last_reg         <= last_hit;
        end
    end

    abb_blend u_blend (
        .source_pixel  (s1_source_reg),
        .dest_pixel    (s1_dest_reg),
        .blended_pixel (blend_pix)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
        if (advance) begin
            m_blended_pixel <= blend_pix;
            m_dest_index    <= s1_dest_index_reg;
            m_source_index  <= s1_source_index_reg;
            m_last_pixel    <= s1_last_reg;
        end
    end

endmodule

// ----- src/abb_blend.sv -----
module abb_blend (
    input  logic [abb_pkg::PIXEL_W-1:0] source_pixel,
    input  logic [abb_pkg::PIXEL_W-1:0] dest_pixel,
    output logic [abb_pkg::PIXEL_W-1:0] blended_pixel
);

    logic [8:0]  weight;
    logic [8:0]  weight_inv;
    logic [33:0] rb_sum;
    logic [33:0] g_sum;
    logic [31:0] rb_lane;
    logic [31:0] g_lane;

    // Source weight alpha+1, destination gets the rest of 256
    assign weight     = {1'b0, source_pixel[abb_pkg::ALPHA_LSB +: 8]} + 9'd1;
    assign weight_inv = 9'(abb_pkg::BLEND_ONE) - weight;

    // Red/blue packed lane and green lane
    assign rb_sum = 34'(source_pixel & abb_pkg::RB_MASK) * 34'(weight)
                  + 34'(dest_pixel & abb_pkg::RB_MASK) * 34'(weight_inv);
    assign g_sum  = 34'(source_pixel & abb_pkg::G_MASK) * 34'(weight)
                  + 34'(dest_pixel & abb_pkg::G_MASK) * 34'(weight_inv);

    assign rb_lane = 32'(rb_sum >> abb_pkg::BLEND_SHIFT);
    assign g_lane  = 32'(g_sum >> abb_pkg::BLEND_SHIFT);

    assign blended_pixel = (rb_lane & abb_pkg::RB_MASK) | (g_lane & abb_pkg::G_MASK)
                         | abb_pkg::ALPHA_OPAQUE;

endmodule

// ----- sim/alpha_blend_blit_tb.sv -----
module alpha_blend_blit_tb;

    // Surface geometry, kept equal to the block's defaults
    localparam int DST_W      = 1024;
    localparam int DST_H      = 1024;
    localparam int DST_P      = 1024;
    localparam int SRC_W      = 1024;
    localparam int SRC_H      = 1024;
    localparam int SRC_P      = 1024;
    localparam int MIN_W      = (DST_W < SRC_W) ? DST_W : SRC_W;
    localparam int MIN_H      = (DST_H < SRC_H) ? DST_H : SRC_H;

    localparam int RANDOM_PIXELS  = 450;
    localparam int STALL_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 8;

    localparam int PIX_W  = abb_pkg::PIXEL_W;
    localparam int IDX_W  = abb_pkg::INDEX_W;
    localparam int CIDX_W = abb_pkg::CFG_INDEX_W;
    localparam int CDAT_W = abb_pkg::CFG_DATA_W;

    // Register indexes past the end of the map; writes there are dropped
    localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [IDX_W-1:0] didx;
        logic [IDX_W-1:0] sidx;
        logic             last;
    } blit_out_t;

    typedef enum logic {
        ROW_CFG,
        ROW_PIXEL
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CIDX_W-1:0]     idx;
        logic [CDAT_W-1:0]     data;
        logic [PIX_W-1:0]      src;
        logic [PIX_W-1:0]      dst;
        logic                  typed;
        blit_out_t             want;
    } stim_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [PIX_W-1:0]        s_source_pixel;
    logic [PIX_W-1:0]        s_dest_pixel;
    logic                    m_valid;
    logic                    m_ready;
    logic [PIX_W-1:0]        m_blended_pixel;
    logic [IDX_W-1:0]        m_dest_index;
    logic [IDX_W-1:0]        m_source_index;
    logic                    m_last_pixel;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CIDX_W-1:0]       cfg_index;
    logic [CDAT_W-1:0]       cfg_data;

    // Hand-written result that goes with the pixel now on the bus
    logic                    pix_typed;
    blit_out_t               pix_want;

    // Mirror of the register file and the raster walk
    logic [CDAT_W-1:0]       cfg_regs [6];
    int unsigned             walk_col;
    int unsigned             walk_row;
    logic [IDX_W-1:0]        dest_base;
    logic [IDX_W-1:0]        src_base;

    blit_out_t               pixels_in_flight [$];
    stim_row_t               directed_rows [$];
    int                      mismatch_count;
    int                      stall_cycles;
    bit                      back_to_back;

    alpha_blend_blit #(
        .DST_WIDTH  (DST_W),
        .DST_HEIGHT (DST_H),
        .DST_PITCH  (DST_P),
        .SRC_WIDTH  (SRC_W),
        .SRC_HEIGHT (SRC_H),
        .SRC_PITCH  (SRC_P)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_pixel  (s_source_pixel),
        .s_dest_pixel    (s_dest_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blended_pixel (m_blended_pixel),
        .m_dest_index    (m_dest_index),
        .m_source_index  (m_source_index),
        .m_last_pixel    (m_last_pixel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Geometry and blend model
    // ---------------------------------------------------------------

    // Zero counts as one; anything past the smaller surface saturates
    function automatic int unsigned eff_dim(logic [CDAT_W-1:0] req, int unsigned lim);
        int unsigned r;
        r = 32'(req);
        if (r == 0) r = 1;
        if (r > lim) r = lim;
        return r;
    endfunction

    function automatic int clamp_org(logic [CDAT_W-1:0] raw, int hi);
        int v;
        v = 32'($signed(raw));
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_walk();
        int w, h, dx, dy, sx, sy;
        w  = int'(eff_dim(cfg_regs[abb_pkg::CFG_RECT_WIDTH], MIN_W));
        h  = int'(eff_dim(cfg_regs[abb_pkg::CFG_RECT_HEIGHT], MIN_H));
        dx = clamp_org(cfg_regs[abb_pkg::CFG_DEST_ORIGIN_X], DST_W - w);
        dy = clamp_org(cfg_regs[abb_pkg::CFG_DEST_ORIGIN_Y], DST_H - h);
        sx = clamp_org(cfg_regs[abb_pkg::CFG_SOURCE_ORIGIN_X], SRC_W - w);
        sy = clamp_org(cfg_regs[abb_pkg::CFG_SOURCE_ORIGIN_Y], SRC_H - h);
        walk_col  = 0;
        walk_row  = 0;
        dest_base = IDX_W'(dx + dy * DST_P);
        src_base  = IDX_W'(sx + sy * SRC_P);
    endfunction

    function automatic void apply_cfg(logic [CIDX_W-1:0] idx,
                                      logic [CDAT_W-1:0] data);
        if (idx > abb_pkg::CFG_RECT_HEIGHT) return;
        if (idx >= abb_pkg::CFG_RECT_WIDTH)
            cfg_regs[idx] = {1'b0, data[abb_pkg::SIZE_W-1:0]};
        else
            cfg_regs[idx] = data;
        restart_walk();
    endfunction

    // Blend one pixel and advance the raster walk
    function automatic blit_out_t blit_step(logic [PIX_W-1:0] src,
                                            logic [PIX_W-1:0] dst);
        blit_out_t   r;
        logic [63:0] a, inv_a, src_rb, src_g, dst_rb, dst_g, rb, g;
        int unsigned w, h;
        bit          line_end, last;
        w      = eff_dim(cfg_regs[abb_pkg::CFG_RECT_WIDTH], MIN_W);
        h      = eff_dim(cfg_regs[abb_pkg::CFG_RECT_HEIGHT], MIN_H);
        a      = 64'(src[abb_pkg::ALPHA_LSB +: 8]);
        a      = a + 64'd1;
        inv_a  = 64'(abb_pkg::BLEND_ONE) - a;
        src_rb = 64'(src & abb_pkg::RB_MASK);
        src_g  = 64'(src & abb_pkg::G_MASK);
        dst_rb = 64'(dst & abb_pkg::RB_MASK);
        dst_g  = 64'(dst & abb_pkg::G_MASK);
        rb     = (src_rb * a + dst_rb * inv_a) >> abb_pkg::BLEND_SHIFT;
        g      = (src_g * a + dst_g * inv_a) >> abb_pkg::BLEND_SHIFT;
        line_end = (walk_col + 32'd1 >= w);
        last     = line_end && (walk_row + 32'd1 >= h);

        r.pix  = (rb[31:0] & abb_pkg::RB_MASK) | (g[31:0] & abb_pkg::G_MASK)
               | abb_pkg::ALPHA_OPAQUE;
        r.didx = dest_base + IDX_W'(walk_col);
        r.sidx = src_base + IDX_W'(walk_col);
        r.last = last;

        if (last) begin
            restart_walk();
        end else if (line_end) begin
            walk_col  = 0;
            walk_row  = walk_row + 32'd1;
            dest_base = dest_base + IDX_W'(DST_P);
            src_base  = src_base + IDX_W'(SRC_P);
        end else begin
            walk_col = walk_col + 32'd1;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : monitor
        blit_out_t got;
        blit_out_t want;
        if (!aresetn) begin
            stall_cycles = 0;
        end else begin
            // result transfer, compared against the oldest pending pixel
            if (m_valid && m_ready) begin
                got = {m_blended_pixel, m_dest_index, m_source_index, m_last_pixel};
                if (pixels_in_flight.size() == 0) begin
                    flag_mismatch("unexpected result", got.pix, '0);
                end else begin
                    want = pixels_in_flight.pop_front();
                    if (got.pix !== want.pix)
                        flag_mismatch("blended_pixel", got.pix, want.pix);
                    if (got.didx !== want.didx)
                        flag_mismatch("dest_index", 32'(got.didx), 32'(want.didx));
                    if (got.sidx !== want.sidx)
                        flag_mismatch("source_index", 32'(got.sidx), 32'(want.sidx));
                    if (got.last !== want.last)
                        flag_mismatch("last_pixel", 32'(got.last), 32'(want.last));
                end
            end

            if (cfg_valid && cfg_ready)
                apply_cfg(cfg_index, cfg_data);

            // input transfer: the model always advances, typed rows override
            if (s_valid && s_ready) begin
                want = blit_step(s_source_pixel, s_dest_pixel);
                if (pix_typed)
                    want = pix_want;
                pixels_in_flight.push_back(want);
            end

            // watchdog on cycles with no transfer anywhere
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL alpha_blend_blit");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Mostly short gaps, a few long ones, none during back-to-back stretches
    function automatic int unsigned idle_len();
        int unsigned r;
        if (back_to_back) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: ready in bursts with random stalls in between
    initial begin : sink
        int unsigned hold;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            m_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            hold = idle_len();
            if (hold != 0) begin
                m_ready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
        end
    end

    // Holds the sender until every pixel sent has come back
    task automatic drain_pixels();
        s_valid = 1'b0;
        while (pixels_in_flight.size() != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
        drain_pixels();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_pixel(logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst,
                              logic typed, blit_out_t want);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_source_pixel = src;
        s_dest_pixel   = dst;
        pix_typed      = typed;
        pix_want       = want;
        s_valid        = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void add_cfg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
        directed_rows.push_back({ROW_CFG, idx, data, 32'h0, 32'h0, 1'b0, blit_out_t'(0)});
    endfunction

    function automatic void add_pix(logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
        directed_rows.push_back({ROW_PIXEL, CFG_SPARE_LO, 12'h0, src, dst, 1'b0,
                                 blit_out_t'(0)});
    endfunction

    function automatic void add_typed(logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst,
                                      blit_out_t want);
        directed_rows.push_back({ROW_PIXEL, CFG_SPARE_LO, 12'h0, src, dst, 1'b1, want});
    endfunction

    // Alpha pinned to its extremes half of the time
    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        p = $urandom();
        case ($urandom_range(0, 3))
            0: p[abb_pkg::ALPHA_LSB +: 8] = 8'h00;
            1: p[abb_pkg::ALPHA_LSB +: 8] = 8'hFF;
            default: ;
        endcase
        return p;
    endfunction

    initial begin : driver
        stim_row_t               row;
        int                      sent;
        int unsigned             n;
        logic [CIDX_W-1:0]       idx;
        logic [CDAT_W-1:0]       data;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_source_pixel = '0;
        s_dest_pixel   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = abb_pkg::CFG_DEST_ORIGIN_X;
        cfg_data       = '0;
        pix_typed      = 1'b0;
        pix_want       = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        back_to_back   = 1'b0;

        // register reset values: origins at zero, one-by-one rectangle
        cfg_regs[abb_pkg::CFG_DEST_ORIGIN_X]   = '0;
        cfg_regs[abb_pkg::CFG_DEST_ORIGIN_Y]   = '0;
        cfg_regs[abb_pkg::CFG_SOURCE_ORIGIN_X] = '0;
        cfg_regs[abb_pkg::CFG_SOURCE_ORIGIN_Y] = '0;
        cfg_regs[abb_pkg::CFG_RECT_WIDTH]      = 12'd1;
        cfg_regs[abb_pkg::CFG_RECT_HEIGHT]     = 12'd1;
        restart_walk();

        // After reset: single-pixel rectangle, blend extremes
        add_typed(32'hFFFF_FFFF, 32'h0000_0000, {32'hFFFF_FFFF, 20'h0, 20'h0, 1'b1});
        add_typed(32'h0000_0000, 32'hFFFF_FFFF, {32'hFFFE_FEFE, 20'h0, 20'h0, 1'b1});
        // zero alpha: red/blue carry must not leak across lanes
        add_typed(32'h00FF_FFFF, 32'h0000_0000, {32'hFF00_0000, 20'h0, 20'h0, 1'b1});
        // opaque black source hides destination, alpha forced
        add_typed(32'hFF00_0000, 32'hFF12_3456, {32'hFF00_0000, 20'h0, 20'h0, 1'b1});

        // 3x2 rectangle, spare index written mid-walk must not restart it
        add_cfg(abb_pkg::CFG_RECT_WIDTH, 12'd3);
        add_cfg(abb_pkg::CFG_RECT_HEIGHT, 12'd2);
        add_pix(32'h80C0_4020, 32'h1020_3040);
        add_pix(32'h7F01_02FE, 32'hFEDC_BA98);
        add_cfg(CFG_SPARE_LO, 12'hFFF);
        add_pix(32'h4055_AA55, 32'h00AA_55AA);
        add_cfg(CFG_SPARE_HI, 12'hABC);
        add_pix(32'hC012_3456, 32'h0065_4321);
        add_pix(32'h01FF_00FF, 32'hFF00_FF00);
        add_pix(32'hFE00_FF00, 32'h00FF_00FF);
        add_pix(32'h3333_3333, 32'hCCCC_CCCC);

        // zero size, origins at the signed extremes
        add_cfg(abb_pkg::CFG_RECT_WIDTH, 12'd0);
        add_cfg(abb_pkg::CFG_RECT_HEIGHT, 12'd0);
        add_cfg(abb_pkg::CFG_DEST_ORIGIN_X, 12'h800);
        add_cfg(abb_pkg::CFG_DEST_ORIGIN_Y, 12'h7FF);
        add_cfg(abb_pkg::CFG_SOURCE_ORIGIN_X, 12'h7FF);
        add_cfg(abb_pkg::CFG_SOURCE_ORIGIN_Y, 12'h800);
        add_typed(32'hFFAB_CDEF, 32'h1234_5678, {32'hFFAB_CDEF, 20'hFFC00, 20'h003FF, 1'b1});
        add_pix(32'h5A5A_5A5A, 32'hA5A5_A5A5);

        // oversize rectangle saturates; origins then clamp to zero
        add_cfg(abb_pkg::CFG_RECT_WIDTH, 12'hFFF);
        add_cfg(abb_pkg::CFG_RECT_HEIGHT, 12'h7FF);
        add_typed(32'hFF00_0000, 32'h0BAD_F00D, {32'hFF00_0000, 20'h0, 20'h0, 1'b0});
        add_pix(32'h9988_7766, 32'h5544_3322);
        add_pix(32'h0011_2233, 32'hFFEE_DDCC);

        // full-width single line
        add_cfg(abb_pkg::CFG_RECT_WIDTH, 12'h400);
        add_cfg(abb_pkg::CFG_RECT_HEIGHT, 12'd1);
        add_pix(32'hFFFF_0000, 32'h0000_FFFF);
        add_pix(32'h7F7F_7F7F, 32'h8080_8080);

        // hold reset, then release at a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                cfg_write(row.idx, row.data);
            else
                send_pixel(row.src, row.dst, row.typed, row.want);
        end
        pix_typed = 1'b0;

        // random phases: drain, reconfigure, then a burst of pixels
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            drain_pixels();
            back_to_back = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 3)) begin
                idx  = CIDX_W'($urandom_range(0, 7));
                data = CDAT_W'($urandom_range(0, 4095));
                // keep most rectangles small so the walk wraps often
                if ((idx == abb_pkg::CFG_RECT_WIDTH || idx == abb_pkg::CFG_RECT_HEIGHT) &&
                    $urandom_range(0, 99) < 85)
                    data = CDAT_W'($urandom_range(0, 6));
                cfg_write(idx, data);
            end
            n = $urandom_range(1, 30);
            repeat (n) begin
                send_pixel(rand_pixel(), $urandom(), 1'b0, blit_out_t'(0));
                sent++;
            end
        end

        // wind down
        back_to_back = 1'b0;
        drain_pixels();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS alpha_blend_blit");
        else
            $display("FAIL alpha_blend_blit");
        $finish;
    end

endmodule
